// File: src/battery_gauge_sequencer_macros.svh
// assertion macros shared by the battery gauge sequencer checker
// no dependencies
`ifndef BATTERY_GAUGE_SEQUENCER_MACROS_SVH
`define BATTERY_GAUGE_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BGS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("battery gauge sequencer check failed");

// next-cycle implication, disabled while reset is low
`define BGS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("battery gauge sequencer check failed");

`endif

// File: src/bgs_pkg.sv
// types, widths and constants of the battery gauge sequencer
// no dependencies
`timescale 1ns / 1ps

package bgs_pkg;

  localparam int unsigned NOW_W     = 32;
  localparam int unsigned ADC_W     = 12;
  localparam int unsigned AVG_W     = 12;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  localparam int unsigned SAMPLES_PER_BURST = 16;
  localparam int unsigned SAMPLE_SHIFT      = $clog2(SAMPLES_PER_BURST);
  localparam int unsigned PCT_MAX           = 100;
  localparam int unsigned Q16_HALF          = 32768;

  localparam logic [GAIN_W-1:0]          GAIN_RESET   = 16'd14076;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -32'sd44657098;
  localparam logic [MS_W-1:0]            PERIOD_RESET = 16'd10000;
  localparam logic [MS_W-1:0]            SETTLE_RESET = 16'd100;

  typedef enum logic [1:0] {
    PH_FINISH  = 2'd0,
    PH_PREPARE = 2'd1,
    PH_START   = 2'd2,
    PH_RESULT  = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_PERIOD = 2'd2,
    REG_SETTLE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]          gain_q16;
    logic signed [OFFSET_W-1:0] offset_q16;
    logic [MS_W-1:0]            period_ms;
    logic [MS_W-1:0]            settle_ms;
  } bgs_cfg_t;

endpackage

// File: src/bgs_if.sv
// valid/ready channel interfaces: input transaction, result transaction, config write
// depends on bgs_pkg
`timescale 1ns / 1ps

interface bgs_in_if;
  logic                      valid;
  logic                      ready;
  logic [bgs_pkg::NOW_W-1:0] now_ms;
  logic                      adc_ready;
  logic [bgs_pkg::ADC_W-1:0] adc_value;

  modport source (output valid, output now_ms, output adc_ready, output adc_value,
                  input ready);
  modport sink (input valid, input now_ms, input adc_ready, input adc_value,
                output ready);
endinterface

interface bgs_out_if;
  logic                      valid;
  logic                      ready;
  logic                      measurement_done;
  logic [bgs_pkg::PCT_W-1:0] percent;
  logic [bgs_pkg::AVG_W-1:0] average_raw;
  logic                      sense_enable;
  logic                      adc_start;

  modport source (output valid, output measurement_done, output percent,
                  output average_raw, output sense_enable, output adc_start,
                  input ready);
  modport sink (input valid, input measurement_done, input percent,
                input average_raw, input sense_enable, input adc_start,
                output ready);
endinterface

interface bgs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bgs_pkg::CFG_IDX_W-1:0] index;
  logic [bgs_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/bgs_cfg_regs.sv
// configuration register file: gain, offset, period and settle time
// depends on bgs_pkg
`timescale 1ns / 1ps

module bgs_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]     wr_index_i,
  input  logic [bgs_pkg::CFG_DAT_W-1:0]     wr_data_i,
  output bgs_pkg::bgs_cfg_t                 cfg_o
);
  import bgs_pkg::*;

  bgs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        REG_GAIN:   cfg_d.gain_q16   = wr_data_i[GAIN_W-1:0];
        REG_OFFSET: cfg_d.offset_q16 = $signed(wr_data_i[OFFSET_W-1:0]);
        REG_PERIOD: cfg_d.period_ms  = wr_data_i[MS_W-1:0];
        REG_SETTLE: cfg_d.settle_ms  = wr_data_i[MS_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_q16   <= GAIN_RESET;
      cfg_q.offset_q16 <= OFFSET_RESET;
      cfg_q.period_ms  <= PERIOD_RESET;
      cfg_q.settle_ms  <= SETTLE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/bgs_percent.sv
// maps an averaged adc count to a 0..100 percentage through q16 gain and offset
// depends on bgs_pkg
`timescale 1ns / 1ps

module bgs_percent (
  input  logic [bgs_pkg::AVG_W-1:0]           average_i,
  input  logic [bgs_pkg::GAIN_W-1:0]          gain_q16_i,
  input  logic signed [bgs_pkg::OFFSET_W-1:0] offset_q16_i,
  output logic [bgs_pkg::PCT_W-1:0]           percent_o
);
  import bgs_pkg::*;

  localparam int unsigned PROD_W = AVG_W + GAIN_W;
  localparam int unsigned SUM_W2 = OFFSET_W + 2;
  localparam int unsigned RND_W  = SUM_W2 - 16;

  logic [PROD_W-1:0]        prod;
  logic signed [SUM_W2-1:0] value;
  logic signed [SUM_W2-1:0] rounded;
  logic [RND_W-1:0]         whole;

  always_comb begin
    prod    = PROD_W'(average_i) * PROD_W'(gain_q16_i);
    value   = $signed({{(SUM_W2 - PROD_W){1'b0}}, prod})
            + {{(SUM_W2 - OFFSET_W){offset_q16_i[OFFSET_W-1]}}, offset_q16_i};
    rounded = value + SUM_W2'(Q16_HALF);
    whole   = rounded[SUM_W2-1:16];
    if (value[SUM_W2-1]) begin
      percent_o = '0;
    end else if (whole > RND_W'(PCT_MAX)) begin
      percent_o = PCT_W'(PCT_MAX);
    end else begin
      percent_o = whole[PCT_W-1:0];
    end
  end

endmodule

// File: src/bgs_core.sv
// input register, phase sequencer with measurement state, and result register
// depends on bgs_pkg and bgs_percent
`timescale 1ns / 1ps

module bgs_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bgs_pkg::bgs_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bgs_pkg::NOW_W-1:0]     now_ms_i,
  input  logic                          adc_ready_i,
  input  logic [bgs_pkg::ADC_W-1:0]     adc_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          measurement_done_o,
  output logic [bgs_pkg::PCT_W-1:0]     percent_o,
  output logic [bgs_pkg::AVG_W-1:0]     average_raw_o,
  output logic                          sense_enable_o,
  output logic                          adc_start_o
);
  import bgs_pkg::*;

  // input stage
  logic             in_valid_q, in_valid_d;
  logic [NOW_W-1:0] now_q;
  logic             rdy_q;
  logic [ADC_W-1:0] adc_q;

  // measurement state
  phase_e           phase_q, phase_d;
  logic [NOW_W-1:0] due_q, due_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AVG_W-1:0] avg_q, avg_d;
  logic [PCT_W-1:0] pct_q, pct_d;
  logic             en_q, en_d;

  // result stage
  logic             out_valid_q, out_valid_d;
  logic             done_q, done_d;
  logic             start_q, start_d;

  logic             accept;
  logic             advance;
  logic             is_due;
  logic [CNT_W-1:0] cnt_inc;
  logic [AVG_W-1:0] avg_new;
  logic [PCT_W-1:0] pct_new;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign is_due  = due_q <= now_q;
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign avg_new = sum_q[SAMPLE_SHIFT +: AVG_W];

  bgs_percent u_percent (
    .average_i    (avg_new),
    .gain_q16_i   (cfg_i.gain_q16),
    .offset_q16_i (cfg_i.offset_q16),
    .percent_o    (pct_new)
  );

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (advance && is_due) begin
      unique case (phase_q)
        PH_FINISH:  phase_d = PH_PREPARE;
        PH_PREPARE: phase_d = PH_START;
        PH_START:   phase_d = PH_RESULT;
        PH_RESULT: begin
          if (rdy_q) begin
            phase_d = (cnt_inc >= CNT_W'(SAMPLES_PER_BURST)) ? PH_FINISH : PH_START;
          end
        end
        default:    phase_d = phase_q;
      endcase
    end
  end

  // datapath and result per phase
  always_comb begin
    due_d   = due_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    avg_d   = avg_q;
    pct_d   = pct_q;
    en_d    = en_q;
    done_d  = 1'b0;
    start_d = 1'b0;
    if (is_due) begin
      unique case (phase_q)
        PH_FINISH: begin
          avg_d  = avg_new;
          pct_d  = pct_new;
          due_d  = now_q + NOW_W'(cfg_i.period_ms);
          sum_d  = '0;
          cnt_d  = '0;
          done_d = 1'b1;
        end
        PH_PREPARE: begin
          en_d  = 1'b1;
          due_d = now_q + NOW_W'(cfg_i.settle_ms);
        end
        PH_START: begin
          start_d = 1'b1;
        end
        PH_RESULT: begin
          if (rdy_q) begin
            sum_d = sum_q + SUM_W'(adc_q);
            cnt_d = cnt_inc;
            if (cnt_inc >= CNT_W'(SAMPLES_PER_BURST)) begin
              en_d = 1'b0;
            end
          end
        end
        default: begin
          en_d = en_q;
        end
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_PREPARE;
      due_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_q       <= '0;
      pct_q       <= '0;
      en_q        <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      if (advance) begin
        due_q <= due_d;
        sum_q <= sum_d;
        cnt_q <= cnt_d;
        avg_q <= avg_d;
        pct_q <= pct_d;
        en_q  <= en_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_ms_i;
      rdy_q <= adc_ready_i;
      adc_q <= adc_value_i;
    end
    if (advance) begin
      done_q         <= done_d;
      start_q        <= start_d;
      percent_o      <= pct_d;
      average_raw_o  <= avg_d;
      sense_enable_o <= en_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign measurement_done_o = done_q;
  assign adc_start_o        = start_q;

endmodule

// File: src/battery_gauge_sequencer.sv
// top level of the battery gauge sequencer
// depends on bgs_pkg, bgs_if, bgs_cfg_regs, bgs_core
`timescale 1ns / 1ps

// Each input transaction is one scheduler call (millisecond time, adc ready flag, adc
// sample) and yields exactly one result transaction. The block takes one transaction
// per cycle unless the result side stalls; each is held in the input register, then
// goes through the phase logic into the result register, where the finish
// step's single 12x16 multiply-add and clamp sets the path. The input side keeps
// accepting while a result waits; it stalls only when both stages are full.
// Configuration writes are always accepted; issue them only while no call is in flight.
// After reset the first due call powers the sense divider.
module battery_gauge_sequencer (
  input  logic   clk_i,
  input  logic   rst_ni,
  bgs_in_if.sink   in_i,
  bgs_out_if.source out_o,
  bgs_cfg_if.sink  cfg_i
);
  import bgs_pkg::*;

  bgs_cfg_t cfg;
  logic     cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  bgs_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_wr),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  bgs_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_i.valid),
    .in_ready_o         (in_i.ready),
    .now_ms_i           (in_i.now_ms),
    .adc_ready_i        (in_i.adc_ready),
    .adc_value_i        (in_i.adc_value),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .measurement_done_o (out_o.measurement_done),
    .percent_o          (out_o.percent),
    .average_raw_o      (out_o.average_raw),
    .sense_enable_o     (out_o.sense_enable),
    .adc_start_o        (out_o.adc_start)
  );

endmodule

// File: src/bgs_checker.sv
// port-level checks of the battery gauge sequencer result channel, bound to the top level
// depends on bgs_pkg and battery_gauge_sequencer_macros.svh
`timescale 1ns / 1ps
`include "battery_gauge_sequencer_macros.svh"

module bgs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      measurement_done_i,
  input logic [bgs_pkg::PCT_W-1:0] percent_i,
  input logic                      sense_enable_i,
  input logic                      adc_start_i
);
  import bgs_pkg::*;

  // percentage never leaves the clamp range
  `BGS_ASSERT_IMPL(a_percent_range, clk_i, rst_ni, out_valid_i, percent_i <= PCT_W'(PCT_MAX))

  // publishing and conversion start come from different phases
  `BGS_ASSERT_IMPL(a_done_start_excl, clk_i, rst_ni, out_valid_i, !(measurement_done_i && adc_start_i))

  // divider is already off when a percentage is published
  `BGS_ASSERT_IMPL(a_done_divider_off, clk_i, rst_ni, out_valid_i && measurement_done_i, !sense_enable_i)

  // a conversion start only happens with the divider powered
  `BGS_ASSERT_IMPL(a_start_divider_on, clk_i, rst_ni, out_valid_i && adc_start_i, sense_enable_i)

  // stalled result transaction stays put
  `BGS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(percent_i) && $stable(measurement_done_i))

endmodule

bind battery_gauge_sequencer bgs_checker u_bgs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .measurement_done_i (out_o.measurement_done),
  .percent_i          (out_o.percent),
  .sense_enable_i     (out_o.sense_enable),
  .adc_start_i        (out_o.adc_start)
);
